/* sv/csig_pkg.sv */
// Shared types, constants and a helper function for the clipmap strip index generator.
// Used by the channel interfaces, every pipeline stage and the top level.
// No dependencies.
package csig_pkg;

    // Field widths.
    localparam int IDX_W   = 16;
    localparam int GRID_W  = 8;
    localparam int OP_W    = 3;
    localparam int SEL_W   = 4;
    localparam int STRIP_W = 7;
    localparam int POS_W   = 9;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [GRID_W-1:0]  grid_t;
    typedef logic [OP_W-1:0]    op_t;
    typedef logic [SEL_W-1:0]   sel_t;
    typedef logic [STRIP_W-1:0] strip_t;
    typedef logic [POS_W-1:0]   pos_t;

    // Piece kinds carried in the opcode field.
    localparam op_t OP_OUTER  = 3'd0;
    localparam op_t OP_GAP    = 3'd1;
    localparam op_t OP_CENTER = 3'd2;
    localparam op_t OP_LTILE  = 3'd3;
    localparam op_t OP_RING   = 3'd4;

    // Piece counts and the ring block length.
    localparam sel_t NUM_TILES      = 4'd12;
    localparam sel_t NUM_SIDES      = 4'd4;
    localparam pos_t RING_BLOCK_LEN = 9'd9;

    // A ring corner is either the outer vertex or the inner one, plus 0..2.
    typedef struct packed {
        logic       use_outer;
        logic [1:0] inc;
    } ring_pick_t;

    localparam ring_pick_t PICK_A  = '{use_outer: 1'b1, inc: 2'd0};
    localparam ring_pick_t PICK_B  = '{use_outer: 1'b1, inc: 2'd1};
    localparam ring_pick_t PICK_C0 = '{use_outer: 1'b0, inc: 2'd0};
    localparam ring_pick_t PICK_C1 = '{use_outer: 1'b0, inc: 2'd1};
    localparam ring_pick_t PICK_C2 = '{use_outer: 1'b0, inc: 2'd2};

    // Stage 1 result: everything the multiply stage needs.
    typedef struct packed {
        logic       oor;
        logic       ring;
        ring_pick_t pick;
        logic       step_is_n;
        logic       addoff;
        logic       off_is_one;
        grid_t      n;
        idx_t       rowfac;
        idx_t       col;
        idx_t       col2;
        idx_t       k;
    } dec_t;

    // Stage 2 result: products and the ring's outer vertex.
    typedef struct packed {
        logic       oor;
        logic       ring;
        ring_pick_t pick;
        logic       addoff;
        logic       off_is_one;
        grid_t      n;
        idx_t       col;
        idx_t       rowprod;
        idx_t       kprod;
        idx_t       outer;
    } mul_t;

    // Stage 3 result: the two operands of the last add.
    typedef struct packed {
        logic oor;
        logic use_outer;
        idx_t outer;
        idx_t sum_a;
        idx_t addend;
    } sum_t;

    // Stage 4 result: the delivered beat.
    typedef struct packed {
        logic oor;
        idx_t vertex;
    } res_t;

    // Vertex order of one ring block; the first two sides use the low order.
    function automatic ring_pick_t ring_pick(input logic hi, input logic [3:0] slot);
        ring_pick_t pick;
        pick = PICK_C2;
        case (slot)
            4'd0:    pick = hi ? PICK_C0 : PICK_A;
            4'd1:    pick = hi ? PICK_A  : PICK_C0;
            4'd2:    pick = PICK_C1;
            4'd3:    pick = hi ? PICK_A  : PICK_B;
            4'd4:    pick = hi ? PICK_B  : PICK_A;
            4'd5:    pick = PICK_C1;
            4'd6:    pick = hi ? PICK_C1 : PICK_B;
            4'd7:    pick = hi ? PICK_B  : PICK_C1;
            default: pick = PICK_C2;
        endcase
        return pick;
    endfunction

endpackage

/* sv/csig_cfg_if.sv */
// Configuration write channel carrying the grid side.
// Depends on csig_pkg.
interface csig_cfg_if;
    logic              valid;
    logic              ready;
    csig_pkg::grid_t   grid_side;

    modport source (output valid, output grid_side, input ready);
    modport sink   (input valid, input grid_side, output ready);
endinterface

/* sv/csig_req_if.sv */
// Request channel: one beat names a piece and a position within it.
// Depends on csig_pkg.
interface csig_req_if;
    logic              valid;
    logic              ready;
    csig_pkg::op_t     opcode;
    csig_pkg::sel_t    piece_select;
    csig_pkg::strip_t  strip_number;
    csig_pkg::pos_t    position;

    modport source (output valid, output opcode, output piece_select,
                    output strip_number, output position, input ready);
    modport sink   (input valid, input opcode, input piece_select,
                    input strip_number, input position, output ready);
endinterface

/* sv/csig_idx_if.sv */
// Result channel: one beat carries a vertex index and its range flag.
// Depends on csig_pkg.
interface csig_idx_if;
    logic              valid;
    logic              ready;
    csig_pkg::idx_t    vertex_index;
    logic              out_of_range;

    modport source (output valid, output vertex_index, output out_of_range, input ready);
    modport sink   (input valid, input vertex_index, input out_of_range, output ready);
endinterface

/* sv/csig_decode.sv */
// Stage 1: range checks and decode of a request into factors, offsets and step.
// Depends on csig_pkg.
module csig_decode (
    input  logic             clk,
    input  logic             en,
    input  csig_pkg::grid_t  n,
    input  csig_pkg::op_t    op,
    input  csig_pkg::sel_t   sel,
    input  csig_pkg::strip_t s,
    input  csig_pkg::pos_t   p,
    output csig_pkg::dec_t   dec
);

    csig_pkg::dec_t dec_reg;
    csig_pkg::dec_t dec_next;

    // Decode of the piece geometry for the current grid side.
    always_comb
    begin
        logic [8:0]       n_plus1;
        logic [6:0]       m;
        logic [6:0]       strips;
        logic [6:0]       nb;
        logic [7:0]       nb1;
        logic [7:0]       cnt;
        logic [9:0]       len;
        logic             p_last;
        logic             oor_pos;
        logic             oor_sel;
        csig_pkg::idx_t   m16;
        csig_pkg::idx_t   s16;
        csig_pkg::idx_t   a;
        csig_pkg::idx_t   a2;
        csig_pkg::idx_t   a3;
        csig_pkg::idx_t   c2;
        csig_pkg::idx_t   c3;
        csig_pkg::idx_t   c3m;
        csig_pkg::idx_t   tile_row;
        csig_pkg::idx_t   tile_col;
        csig_pkg::idx_t   k_strip;
        csig_pkg::idx_t   nb_side;

        n_plus1 = {1'b0, n} + 9'd1;
        m       = n_plus1[8:2];
        strips  = (m == 7'd0) ? 7'd0 : m - 7'd1;
        nb      = (n == '0) ? 7'd0 : 7'((n - 8'd1) >> 1);
        nb1     = {1'b0, nb} + 8'd1;
        m16     = csig_pkg::idx_t'(m);
        s16     = csig_pkg::idx_t'(s);
        a       = m16 - csig_pkg::idx_t'(1);
        a2      = a << 1;
        a3      = a2 + a;
        c2      = a2 + csig_pkg::idx_t'(2);
        c3      = a3 + csig_pkg::idx_t'(2);
        c3m     = a3 + csig_pkg::idx_t'(1);
        nb_side = '0;

        // Outer tile origin: row factor times N plus a column offset.
        tile_row = '0;
        tile_col = '0;
        case (sel)
            4'd0, 4'd1, 4'd2, 4'd3:
            begin
                tile_row = '0;
                tile_col = (sel[1:0] == 2'd0) ? '0 : (sel[1:0] == 2'd1) ? a :
                           (sel[1:0] == 2'd2) ? c2 : c3;
            end
            4'd4:    begin tile_row = a;  tile_col = '0; end
            4'd5:    begin tile_row = a;  tile_col = c3; end
            4'd6:    begin tile_row = c2; tile_col = '0; end
            4'd7:    begin tile_row = c2; tile_col = c3; end
            default:
            begin
                tile_row = c3;
                tile_col = (sel[1:0] == 2'd0) ? '0 : (sel[1:0] == 2'd1) ? a :
                           (sel[1:0] == 2'd2) ? c2 : c3;
            end
        endcase

        dec_next            = '0;
        dec_next.n          = n;
        dec_next.pick       = csig_pkg::PICK_C0;
        oor_sel             = 1'b0;
        cnt                 = {1'b0, m};

        // Per piece: limits, strip length, origin factors, step and offset kind.
        case (op)
            csig_pkg::OP_OUTER:
            begin
                oor_sel         = (sel >= csig_pkg::NUM_TILES) || (s >= strips);
                cnt             = {1'b0, m};
                dec_next.rowfac = tile_row + s16 + csig_pkg::idx_t'(1);
                dec_next.col    = tile_col;
            end
            csig_pkg::OP_GAP:
            begin
                oor_sel = (sel >= csig_pkg::NUM_SIDES) || (s >= 7'd2);
                cnt     = {1'b0, m};
                if (sel[1] == 1'b0)
                begin
                    dec_next.rowfac     = sel[0] ? c3 : '0;
                    dec_next.col        = a2 + s16;
                    dec_next.step_is_n  = 1'b1;
                    dec_next.off_is_one = 1'b1;
                end
                else
                begin
                    dec_next.rowfac = a2 + csig_pkg::idx_t'(1) + s16;
                    dec_next.col    = sel[0] ? c3 : '0;
                end
            end
            csig_pkg::OP_CENTER:
            begin
                oor_sel         = {1'b0, s} >= {m, 1'b0};
                cnt             = {m, 1'b1};
                dec_next.rowfac = m16 + s16;
                dec_next.col    = a;
            end
            csig_pkg::OP_LTILE:
            begin
                oor_sel = (sel >= csig_pkg::NUM_SIDES) || (s >= 7'd2);
                if (s[0] == 1'b0)
                begin
                    cnt             = {m, 1'b1};
                    dec_next.rowfac = sel[0] ? c3 : m16;
                    dec_next.col    = a;
                end
                else
                begin
                    cnt                 = {m, 1'b0};
                    dec_next.rowfac     = sel[0] ? a : m16;
                    dec_next.col        = sel[1] ? c3m : a;
                    dec_next.step_is_n  = 1'b1;
                    dec_next.off_is_one = 1'b1;
                end
            end
            csig_pkg::OP_RING:
            begin
                oor_sel         = (sel >= csig_pkg::NUM_SIDES) || (s >= nb) ||
                                  (p >= csig_pkg::RING_BLOCK_LEN);
                dec_next.ring   = 1'b1;
                dec_next.rowfac = csig_pkg::idx_t'(sel);
                dec_next.col    = s16 << 1;
                nb_side         = (sel[0] ? csig_pkg::idx_t'(nb1) : '0) +
                                  (sel[1] ? csig_pkg::idx_t'({nb1, 1'b0}) : '0);
                dec_next.col2   = nb_side + s16;
                dec_next.pick   = csig_pkg::ring_pick(sel[1], p[3:0]);
            end
            default:
            begin
                oor_sel = 1'b1;
            end
        endcase

        // Strip position: degenerate first, alternating pairs, degenerate last.
        len      = {1'b0, cnt, 1'b0} + 10'd2;
        p_last   = ({1'b0, p} == len - 10'd1);
        oor_pos  = ({1'b0, p} >= len);
        k_strip  = p_last ? (csig_pkg::idx_t'(cnt) - csig_pkg::idx_t'(1)) :
                   (p == '0) ? '0 : csig_pkg::idx_t'((p - 9'd1) >> 1);

        if (!dec_next.ring)
        begin
            dec_next.k      = k_strip;
            dec_next.addoff = p_last || ((p != '0) && !p[0]);
        end
        dec_next.oor = oor_sel || (!dec_next.ring && oor_pos);
    end

    // Stage register; payload only, valid lives in the top level.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

/* sv/csig_multiply.sv */
// Stage 2: origin factor times N, step index times step, and the ring's outer vertex.
// Depends on csig_pkg.
module csig_multiply (
    input  logic            clk,
    input  logic            en,
    input  csig_pkg::dec_t  dec,
    output csig_pkg::mul_t  mul
);

    csig_pkg::mul_t mul_reg;
    csig_pkg::mul_t mul_next;

    // Two narrow multipliers side by side; results wrap at the index width.
    always_comb
    begin
        mul_next            = '0;
        mul_next.oor        = dec.oor;
        mul_next.ring       = dec.ring;
        mul_next.pick       = dec.pick;
        mul_next.addoff     = dec.addoff;
        mul_next.off_is_one = dec.off_is_one;
        mul_next.n          = dec.n;
        mul_next.col        = dec.col;
        mul_next.rowprod    = csig_pkg::idx_t'(dec.rowfac * csig_pkg::idx_t'(dec.n));
        mul_next.kprod      = dec.step_is_n ?
                              csig_pkg::idx_t'(dec.k * csig_pkg::idx_t'(dec.n)) : dec.k;
        mul_next.outer      = csig_pkg::idx_t'({dec.n, 2'b00}) + dec.col2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
        end
    end

    assign mul = mul_reg;

endmodule

/* sv/csig_assemble.sv */
// Stages 3 and 4: sum of origin and step, then the final offset and range masking.
// Depends on csig_pkg.
module csig_assemble (
    input  logic            clk,
    input  logic            en_sum,
    input  logic            en_res,
    input  csig_pkg::mul_t  mul,
    output csig_pkg::res_t  res
);

    csig_pkg::sum_t sum_reg;
    csig_pkg::sum_t sum_next;
    csig_pkg::res_t res_reg;
    csig_pkg::res_t res_next;

    // Stage 3: origin plus step, and the addend for the last add.
    always_comb
    begin
        csig_pkg::idx_t negn;
        csig_pkg::idx_t off;

        negn = '0 - csig_pkg::idx_t'(mul.n);
        off  = mul.addoff ? (mul.off_is_one ? csig_pkg::idx_t'(1) : negn) : '0;

        sum_next.oor       = mul.oor;
        sum_next.use_outer = mul.ring && mul.pick.use_outer;
        sum_next.outer     = mul.outer;
        sum_next.sum_a     = mul.rowprod + mul.col + mul.kprod;
        sum_next.addend    = mul.ring ? csig_pkg::idx_t'(mul.pick.inc) : off;
    end

    // Stage 4: final add; an out-of-range beat reads as zero.
    always_comb
    begin
        csig_pkg::idx_t opnd;

        opnd           = sum_reg.use_outer ? sum_reg.outer : sum_reg.sum_a;
        res_next.oor   = sum_reg.oor;
        res_next.vertex = sum_reg.oor ? '0 : opnd + sum_reg.addend;
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            sum_reg <= sum_next;
        end
        if (en_res)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* sv/clipmap_strip_index_generator.sv */
// Clipmap strip index generator: one vertex index per request beat, for outer
// tiles, gaps, the center tile, L tiles and the fixed ring of a clipmap level.
// The block takes one beat per cycle while the result side does not stall, and passes
// each through the decode, multiply, sum and output registers; the multiply stage with its two
// 16 x 8 products sets the stage depth. Every stage holds its beat while the
// result side stalls, and the output register lets a new request enter while
// a result waits. grid_side resets to 255 and is applied above MAX_GRID_SIDE
// as MAX_GRID_SIDE. No clearing pass follows reset.
// Depends on csig_pkg, the three channel interfaces and the stage modules.
module clipmap_strip_index_generator #(
    parameter int MAX_GRID_SIDE = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    csig_cfg_if.sink    cfg,
    csig_req_if.sink    req,
    csig_idx_if.source  idx
);

    localparam csig_pkg::grid_t MAX_N = csig_pkg::grid_t'(MAX_GRID_SIDE);

    csig_pkg::grid_t grid_side_reg;
    csig_pkg::grid_t n_sat;

    logic valid_s1_reg;
    logic valid_s2_reg;
    logic valid_s3_reg;
    logic valid_s4_reg;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    csig_pkg::dec_t dec;
    csig_pkg::mul_t mul;
    csig_pkg::res_t res;

    // Configuration register; always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= 8'd255;
        end
        else if (cfg.valid)
        begin
            grid_side_reg <= cfg.grid_side;
        end
    end

    assign n_sat = (grid_side_reg > MAX_N) ? MAX_N : grid_side_reg;

    // A stage loads when it is empty or its successor moves on.
    assign en4 = !valid_s4_reg || idx.ready;
    assign en3 = !valid_s3_reg || en4;
    assign en2 = !valid_s2_reg || en3;
    assign en1 = !valid_s1_reg || en2;

    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            valid_s4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                valid_s1_reg <= req.valid;
            end
            if (en2)
            begin
                valid_s2_reg <= valid_s1_reg;
            end
            if (en3)
            begin
                valid_s3_reg <= valid_s2_reg;
            end
            if (en4)
            begin
                valid_s4_reg <= valid_s3_reg;
            end
        end
    end

    // Pipeline stages.
    csig_decode u_decode (
        .clk (clk),
        .en  (en1),
        .n   (n_sat),
        .op  (req.opcode),
        .sel (req.piece_select),
        .s   (req.strip_number),
        .p   (req.position),
        .dec (dec)
    );

    csig_multiply u_multiply (
        .clk (clk),
        .en  (en2),
        .dec (dec),
        .mul (mul)
    );

    csig_assemble u_assemble (
        .clk    (clk),
        .en_sum (en3),
        .en_res (en4),
        .mul    (mul),
        .res    (res)
    );

    // Result channel.
    assign idx.valid        = valid_s4_reg;
    assign idx.vertex_index = res.vertex;
    assign idx.out_of_range = res.oor;

    // An out-of-range beat always carries a zero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx.valid && idx.out_of_range |-> idx.vertex_index == '0)
        else $error("out-of-range beat with nonzero index");

    // A full pipeline with a stalled output must refuse new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_s1_reg && valid_s2_reg && valid_s3_reg && valid_s4_reg && !idx.ready
        |-> !req.ready)
        else $error("request accepted into a full stalled pipeline");

    // An unknown piece kind is flagged out of range by the decode stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.opcode > csig_pkg::OP_RING) |=> dec.oor)
        else $error("unknown piece kind not flagged out of range");

    // A configuration beat lands in the grid side register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> grid_side_reg == $past(cfg.grid_side))
        else $error("grid side write lost");

endmodule

/* tb/clipmap_strip_index_generator_test.sv */
// Self-checking testbench for the clipmap strip index generator.
// Drives request beats and grid-side writes, predicts each vertex index and flag,
// and compares every result beat. Depends on csig_pkg and the three channel interfaces.
module clipmap_strip_index_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [31:0] word_t;

    // One predicted result beat.
    typedef struct {
        csig_pkg::idx_t vertex;
        logic           past_end;
    } index_result_t;

    // Opcodes the block does not know.
    localparam csig_pkg::op_t OP_UNUSED_LO = 3'd5;
    localparam csig_pkg::op_t OP_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n;

    csig_cfg_if cfg_ch ();
    csig_req_if req_ch ();
    csig_idx_if idx_ch ();

    clipmap_strip_index_generator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .idx   (idx_ch)
    );

    // Predictor state and scoreboard.
    csig_pkg::grid_t grid_now;
    index_result_t   expected_indices[$];
    index_result_t   head;
    int              fail_count;
    int              cycle_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_left;

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    // One index of a strip: degenerate first, alternating pairs, degenerate last.
    function automatic word_t strip_walk(input word_t base, input word_t step,
                                         input word_t off, input word_t count,
                                         input word_t p, output logic past_end);
        word_t len;
        word_t i;
        len = 32'd2 * count + 32'd2;
        past_end = 1'b0;
        if (p >= len)
        begin
            past_end = 1'b1;
            return 32'd0;
        end
        if (p == 32'd0)
            return base;
        if (p == len - 32'd1)
            return base + (count - 32'd1) * step + off;
        i = (p - 32'd1) >> 1;
        return base + i * step + (((p - 32'd1) & 32'd1) != 0 ? off : 32'd0);
    endfunction

    // First vertex of one of the twelve outer tiles.
    function automatic word_t tile_origin(input word_t t, input word_t m, input word_t n);
        word_t a;
        word_t col[4];
        word_t row[4];
        a = m - 32'd1;
        col[0] = 32'd0;
        col[1] = a;
        col[2] = 32'd2 * a + 32'd2;
        col[3] = 32'd3 * a + 32'd2;
        row[0] = 32'd0;
        row[1] = a * n;
        row[2] = (32'd2 * a + 32'd2) * n;
        row[3] = (32'd3 * a + 32'd2) * n;
        if (t < 32'd4)
            return row[0] + col[t[1:0]];
        case (t)
            32'd4:   return row[1];
            32'd5:   return row[1] + col[3];
            32'd6:   return row[2];
            32'd7:   return row[2] + col[3];
            default: return row[3] + col[t[1:0]];
        endcase
    endfunction

    // One index of a fixed-ring block; the first two sides use the other order.
    function automatic word_t ring_vertex(input word_t side, input word_t blk,
                                          input word_t p, input word_t n, input word_t nb);
        word_t va;
        word_t vb;
        word_t c0;
        word_t lo[9];
        word_t hi[9];
        va = 32'd4 * n + side * (nb + 32'd1) + blk;
        vb = va + 32'd1;
        c0 = side * n + 32'd2 * blk;
        lo[0] = va;        lo[1] = c0;        lo[2] = c0 + 32'd1;
        lo[3] = vb;        lo[4] = va;        lo[5] = c0 + 32'd1;
        lo[6] = vb;        lo[7] = c0 + 32'd1; lo[8] = c0 + 32'd2;
        hi[0] = c0;        hi[1] = va;        hi[2] = c0 + 32'd1;
        hi[3] = va;        hi[4] = vb;        hi[5] = c0 + 32'd1;
        hi[6] = c0 + 32'd1; hi[7] = vb;        hi[8] = c0 + 32'd2;
        return (side < 32'd2) ? lo[p[3:0]] : hi[p[3:0]];
    endfunction

    // Expected result beat for one request under the current grid side.
    function automatic index_result_t predict_vertex(input csig_pkg::op_t op,
                                                     input csig_pkg::sel_t sel,
                                                     input csig_pkg::strip_t s,
                                                     input csig_pkg::pos_t p);
        index_result_t r;
        word_t n;
        word_t m;
        word_t a;
        word_t negn;
        word_t sw;
        word_t pw;
        word_t selw;
        word_t st;
        word_t nb;
        word_t v;
        logic  oor;
        logic  bottom;
        logic  right;
        n    = word_t'(grid_now);
        m    = (n + 32'd1) >> 2;
        a    = m - 32'd1;
        negn = 32'd0 - n;
        sw   = word_t'(s);
        pw   = word_t'(p);
        selw = word_t'(sel);
        v    = 32'd0;
        oor  = 1'b0;
        case (op)
            csig_pkg::OP_OUTER:
            begin
                if (sel >= csig_pkg::NUM_TILES || sw >= (m == 32'd0 ? 32'd0 : m - 32'd1))
                    oor = 1'b1;
                else
                    v = strip_walk(tile_origin(selw, m, n) + (sw + 32'd1) * n,
                                   32'd1, negn, m, pw, oor);
            end
            csig_pkg::OP_GAP:
            begin
                if (sel >= csig_pkg::NUM_SIDES || sw >= 32'd2)
                    oor = 1'b1;
                else if (selw < 32'd2)
                begin
                    // Top and bottom gaps run down a column.
                    st = 32'd2 * a + (selw == 32'd1 ? (32'd3 * a + 32'd2) * n : 32'd0);
                    v = strip_walk(st + sw, n, 32'd1, m, pw, oor);
                end
                else
                begin
                    // Left and right gaps run along a row.
                    st = (32'd2 * a + 32'd1) * n + (selw == 32'd3 ? 32'd3 * a + 32'd2 : 32'd0);
                    v = strip_walk(st + sw * n, 32'd1, negn, m, pw, oor);
                end
            end
            csig_pkg::OP_CENTER:
            begin
                if (sw >= 32'd2 * m)
                    oor = 1'b1;
                else
                    v = strip_walk(m * n + a + sw * n, 32'd1, negn, 32'd2 * m + 32'd1,
                                   pw, oor);
            end
            csig_pkg::OP_LTILE:
            begin
                bottom = (selw == 32'd1) || (selw == 32'd3);
                right  = (selw >= 32'd2);
                if (sel >= csig_pkg::NUM_SIDES || sw >= 32'd2)
                    oor = 1'b1;
                else if (sw == 32'd0)
                begin
                    st = (bottom ? (32'd3 * a + 32'd2) * n : m * n) + a;
                    v = strip_walk(st, 32'd1, negn, 32'd2 * m + 32'd1, pw, oor);
                end
                else
                begin
                    st = (bottom ? a * n : m * n) + (right ? 32'd3 * m - 32'd2 : a);
                    v = strip_walk(st, n, 32'd1, 32'd2 * m, pw, oor);
                end
            end
            csig_pkg::OP_RING:
            begin
                nb = (n == 32'd0) ? 32'd0 : (n - 32'd1) >> 1;
                if (sel >= csig_pkg::NUM_SIDES || sw >= nb || p >= csig_pkg::RING_BLOCK_LEN)
                    oor = 1'b1;
                else
                    v = ring_vertex(selw, sw, pw, n, nb);
            end
            default:
                oor = 1'b1;
        endcase
        r.vertex   = oor ? '0 : v[csig_pkg::IDX_W-1:0];
        r.past_end = oor;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endfunction

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && idx_ch.valid && idx_ch.ready)
        begin
            if (expected_indices.size() == 0)
                note_failure($sformatf("unexpected beat vertex=%0d flag=%0b",
                                       idx_ch.vertex_index, idx_ch.out_of_range));
            else
            begin
                head = expected_indices.pop_front();
                if (idx_ch.vertex_index !== head.vertex)
                    note_failure($sformatf("vertex_index expected %0d got %0d",
                                           head.vertex, idx_ch.vertex_index));
                if (idx_ch.out_of_range !== head.past_end)
                    note_failure($sformatf("out_of_range expected %0b got %0b",
                                           head.past_end, idx_ch.out_of_range));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off while hold_left counts down.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            idx_ch.ready = 1'b0;
        end
        else
            idx_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------

    // Offer one request beat, with random idle cycles before it.
    task automatic send_request(input csig_pkg::op_t op, input csig_pkg::sel_t sel,
                                input csig_pkg::strip_t s, input csig_pkg::pos_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid        = 1'b1;
        req_ch.opcode       = op;
        req_ch.piece_select = sel;
        req_ch.strip_number = s;
        req_ch.position     = p;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_indices.push_back(predict_vertex(op, sel, s, p));
    endtask

    // Stop offering requests and wait for every predicted beat to arrive.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_indices.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_grid_side(input csig_pkg::grid_t value);
        wait_idle();
        @(negedge clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.grid_side = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        grid_now = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic word_t pick_below(input word_t limit);
        return (limit == 32'd0) ? $urandom_range(127) : $urandom_range(limit - 32'd1);
    endfunction

    // Mostly in-range requests for the current grid, with some raw noise.
    task automatic send_random_requests(input int count);
        csig_pkg::op_t    op;
        csig_pkg::sel_t   sel;
        csig_pkg::strip_t s;
        csig_pkg::pos_t   p;
        word_t            m;
        word_t            n;
        word_t            len;
        for (int k = 0; k < count; k++)
        begin
            n = word_t'(grid_now);
            m = (n + 32'd1) >> 2;
            if ($urandom_range(99) < 15)
            begin
                op  = csig_pkg::op_t'($urandom_range(7));
                sel = csig_pkg::sel_t'($urandom_range(15));
                s   = csig_pkg::strip_t'($urandom_range(127));
                p   = csig_pkg::pos_t'($urandom_range(511));
            end
            else
            begin
                op = csig_pkg::op_t'($urandom_range(4));
                case (op)
                    csig_pkg::OP_OUTER:
                    begin
                        sel = csig_pkg::sel_t'($urandom_range(11));
                        s   = csig_pkg::strip_t'(pick_below(m == 32'd0 ? 32'd0 : m - 32'd1));
                        len = 32'd2 * m + 32'd2;
                    end
                    csig_pkg::OP_GAP:
                    begin
                        sel = csig_pkg::sel_t'($urandom_range(3));
                        s   = csig_pkg::strip_t'($urandom_range(1));
                        len = 32'd2 * m + 32'd2;
                    end
                    csig_pkg::OP_CENTER:
                    begin
                        sel = csig_pkg::sel_t'($urandom_range(15));
                        s   = csig_pkg::strip_t'(pick_below(32'd2 * m));
                        len = 32'd4 * m + 32'd4;
                    end
                    csig_pkg::OP_LTILE:
                    begin
                        sel = csig_pkg::sel_t'($urandom_range(3));
                        s   = csig_pkg::strip_t'($urandom_range(1));
                        len = (s == 0) ? 32'd4 * m + 32'd4 : 32'd4 * m + 32'd2;
                    end
                    default:
                    begin
                        sel = csig_pkg::sel_t'($urandom_range(3));
                        s   = csig_pkg::strip_t'(pick_below((n == 32'd0) ? 32'd0 :
                                                            (n - 32'd1) >> 1));
                        len = word_t'(csig_pkg::RING_BLOCK_LEN);
                    end
                endcase
                // Favor the closing degenerate index now and then.
                p = csig_pkg::pos_t'(($urandom_range(7) == 0) ? len - 32'd1 :
                                                                $urandom_range(len - 32'd1));
            end
            send_request(op, sel, s, p);
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Field extremes, every piece kind and the out-of-range cases at N = 255.
    task automatic test_directed();
        send_request(csig_pkg::OP_OUTER,  4'd0,  7'd0,   9'd0);
        send_request(csig_pkg::OP_OUTER,  4'd11, 7'd62,  9'd129);
        send_request(csig_pkg::OP_OUTER,  4'd5,  7'd10,  9'd130);
        send_request(csig_pkg::OP_OUTER,  4'd12, 7'd0,   9'd1);
        send_request(csig_pkg::OP_OUTER,  4'd3,  7'd63,  9'd0);
        send_request(csig_pkg::OP_GAP,    4'd0,  7'd0,   9'd1);
        send_request(csig_pkg::OP_GAP,    4'd1,  7'd1,   9'd2);
        send_request(csig_pkg::OP_GAP,    4'd2,  7'd0,   9'd129);
        send_request(csig_pkg::OP_GAP,    4'd3,  7'd1,   9'd64);
        send_request(csig_pkg::OP_GAP,    4'd4,  7'd0,   9'd0);
        send_request(csig_pkg::OP_GAP,    4'd0,  7'd2,   9'd0);
        send_request(csig_pkg::OP_CENTER, 4'd15, 7'd127, 9'd259);
        send_request(csig_pkg::OP_CENTER, 4'd0,  7'd0,   9'd260);
        send_request(csig_pkg::OP_LTILE,  4'd0,  7'd0,   9'd0);
        send_request(csig_pkg::OP_LTILE,  4'd1,  7'd1,   9'd257);
        send_request(csig_pkg::OP_LTILE,  4'd2,  7'd1,   9'd3);
        send_request(csig_pkg::OP_LTILE,  4'd3,  7'd0,   9'd259);
        send_request(csig_pkg::OP_LTILE,  4'd15, 7'd0,   9'd0);
        send_request(csig_pkg::OP_RING,   4'd1,  7'd126, 9'd8);
        send_request(csig_pkg::OP_RING,   4'd2,  7'd5,   9'd3);
        send_request(csig_pkg::OP_RING,   4'd3,  7'd0,   9'd6);
        send_request(csig_pkg::OP_RING,   4'd0,  7'd127, 9'd0);
        send_request(csig_pkg::OP_RING,   4'd1,  7'd0,   9'd9);
        send_request(OP_UNUSED_LO, 4'd0,  7'd0,   9'd0);
        send_request(OP_UNUSED_HI, 4'd15, 7'd127, 9'd511);
    endtask

    // Random requests over a sweep of grid sides, tiny grids included.
    task automatic test_grid_sweep(input int send_pct, input int recv_pct, input int count);
        csig_pkg::grid_t sides[10] = '{8'd7, 8'd255, 8'd0, 8'd3, 8'd15, 8'd31, 8'd63,
                                       8'd127, 8'd100, 8'd254};
        for (int k = 0; k < 11; k++)
        begin
            write_grid_side((k < 10) ? sides[k] : csig_pkg::grid_t'($urandom_range(255)));
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            send_random_requests(count / 11);
        end
    endtask

    // Result side held off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        write_grid_side(8'd255);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 200;
        send_random_requests(60);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.grid_side    = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = csig_pkg::OP_OUTER;
        req_ch.piece_select = '0;
        req_ch.strip_number = '0;
        req_ch.position     = '0;
        idx_ch.ready        = 1'b0;
        grid_now            = 8'd255;
        fail_count          = 0;
        cycle_count         = 0;
        hold_left           = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 51;
        test_directed();
        test_grid_sweep(36, 51, 480);
        test_grid_sweep(51, 36, 480);
        test_grid_sweep(0, 0, 480);
        test_output_stall();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/csig_pkg.sv
sv/csig_cfg_if.sv
sv/csig_req_if.sv
sv/csig_idx_if.sv
sv/csig_decode.sv
sv/csig_multiply.sv
sv/csig_assemble.sv
sv/clipmap_strip_index_generator.sv
tb/clipmap_strip_index_generator_test.sv
